// File: src/delta_list_sleep_queue_unit_defines.svh
// Assertion macros for the delta list sleep queue.
`ifndef DELTA_LIST_SLEEP_QUEUE_UNIT_DEFINES_SVH
`define DELTA_LIST_SLEEP_QUEUE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DLSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DLSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DLSQ_ASSERT_IMP(lbl, ante, cons, msg)
`define DLSQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/dlsq_pkg.sv
// Shared codes and control types for the delta list sleep queue.
package dlsq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_WAKE   = 2'd2;

  // insert wave: still looking for its slot, or pushing displaced entries
  localparam logic WAVE_SEARCH = 1'b0;
  localparam logic WAVE_SHIFT  = 1'b1;

  typedef struct packed {
    logic shift;  // take right neighbor's entry
    logic dec;    // decrement own delta (head only)
  } cell_ctl_t;

endpackage

// File: src/dlsq_cell.sv
// One entry cell of the delta list: holds id and delta, passes the insert wave on.
module dlsq_cell import dlsq_pkg::*; #(
  parameter int ID_BITS   = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic                 nb_valid,
  input  logic [ID_BITS-1:0]   nb_id,
  input  logic [TIME_BITS-1:0] nb_delta,
  input  logic                 win_v,
  input  logic                 win_m,
  input  logic [ID_BITS-1:0]   win_id,
  input  logic [TIME_BITS-1:0] win_d,
  output logic                 wout_v,
  output logic                 wout_m,
  output logic [ID_BITS-1:0]   wout_id,
  output logic [TIME_BITS-1:0] wout_d,
  output logic                 valid,
  output logic [ID_BITS-1:0]   id,
  output logic [TIME_BITS-1:0] delta,
  output logic                 absorb
);

  logic                 valid_r, valid_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [TIME_BITS-1:0] delta_r, delta_nxt;
  logic                 wv_r, wv_nxt;
  logic                 wm_r, wm_nxt;
  logic [ID_BITS-1:0]   wid_r, wid_nxt;
  logic [TIME_BITS-1:0] wd_r, wd_nxt;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    delta_nxt = delta_r;
    wv_nxt    = 1'b0;
    wm_nxt    = win_m;
    wid_nxt   = win_id;
    wd_nxt    = win_d;
    absorb    = 1'b0;
    if (ctl.shift) begin
      valid_nxt = nb_valid;
      id_nxt    = nb_id;
      delta_nxt = nb_delta;
    end else if (ctl.dec) begin
      delta_nxt = delta_r - TIME_BITS'(1);
    end else if (win_v) begin
      if (!valid_r) begin
        // free slot: wave ends here
        valid_nxt = 1'b1;
        id_nxt    = win_id;
        delta_nxt = win_d;
        absorb    = 1'b1;
      end else if (win_m == WAVE_SHIFT || win_d < delta_r) begin
        id_nxt    = win_id;
        delta_nxt = win_d;
        wv_nxt    = 1'b1;
        wm_nxt    = WAVE_SHIFT;
        wid_nxt   = id_r;
        // successor of a new entry loses what the new entry took
        wd_nxt    = (win_m == WAVE_SHIFT) ? delta_r : delta_r - win_d;
      end else begin
        wv_nxt = 1'b1;
        wm_nxt = WAVE_SEARCH;
        wd_nxt = win_d - delta_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      wv_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      wv_r    <= wv_nxt;
    end
    id_r    <= id_nxt;
    delta_r <= delta_nxt;
    wm_r    <= wm_nxt;
    wid_r   <= wid_nxt;
    wd_r    <= wd_nxt;
  end

  assign wout_v  = wv_r;
  assign wout_m  = wm_r;
  assign wout_id = wid_r;
  assign wout_d  = wd_r;
  assign valid   = valid_r;
  assign id      = id_r;
  assign delta   = delta_r;

endmodule

// File: src/delta_list_sleep_queue_unit.sv
// Sleep queue kept as a delta list in a chain of entry cells; top level.
// Insert: the insert wave moves one cell per cycle down the chain until a free cell absorbs it;
//   the result beat follows the absorb (or follows the input beat directly when full).
// Tick: decrement in the accept cycle, then one woken beat per cycle while the output is free
//   (chain shifts left once per woken thread); a tick that wakes nobody frees the input again.
// One item at a time; a waiting output beat does not hold off the next input beat.
// Reset (rst_n low, synchronous) empties the queue and drops any output beat.
`include "delta_list_sleep_queue_unit_defines.svh"
module delta_list_sleep_queue_unit import dlsq_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int ID_BITS   = 8,
  parameter int TIME_BITS = 16,
  localparam int IN_W     = ((ID_BITS + TIME_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,   // thread_id, duration (lowest bit up), zero pad
  input  logic            in_tuser,   // op
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,  // woken_id
  output logic [1:0]      out_tuser,  // kind
  output logic            out_tlast   // last
);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_RES, S_WAKE} state_t;

  state_t state_r;

  // cell chain
  logic                 cv  [DEPTH];
  logic [ID_BITS-1:0]   cid [DEPTH];
  logic [TIME_BITS-1:0] cd  [DEPTH];
  logic [DEPTH-1:0]     absorb;
  cell_ctl_t            ctl [DEPTH];

  // insert wave, stage k feeds cell k; the last stage must never fire
  logic [DEPTH:0]       wave_v;
  logic [DEPTH:0]       wave_m;
  logic [ID_BITS-1:0]   wave_id [DEPTH+1];
  logic [TIME_BITS-1:0] wave_d  [DEPTH+1];

  logic                 wave0_v_r;
  logic [ID_BITS-1:0]   wave0_id_r;
  logic [TIME_BITS-1:0] wave0_d_r;

  // pending insert result
  logic [1:0]           pend_kind_r;
  logic [ID_BITS-1:0]   pend_id_r;

  // output beat register
  logic                 out_valid_r;
  logic [1:0]           out_kind_r;
  logic [7:0]           out_id_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic [ID_BITS-1:0]   in_id;
  logic [TIME_BITS-1:0] in_dur;
  logic [TIME_BITS-1:0] in_dur_eff;
  logic                 full;
  logic                 out_free;
  logic                 head_due;
  logic                 wake_go;
  logic                 wake_last;
  logic [ID_BITS+7:0]   pend_ext;
  logic [ID_BITS+7:0]   head_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_id      = in_tdata[ID_BITS-1:0];
  assign in_dur     = in_tdata[ID_BITS+TIME_BITS-1:ID_BITS];
  // zero sleep counts as one tick, so the head never holds a zero delta
  assign in_dur_eff = (in_dur == '0) ? TIME_BITS'(1) : in_dur;
  assign full       = cv[DEPTH-1];
  assign out_free   = !out_valid_r || out_tready;
  assign head_due   = cv[0] && (cd[0] == '0);
  assign wake_go    = (state_r == S_WAKE) && head_due && out_free;
  // entries behind the head with zero delta wake on the same tick
  assign wake_last  = !(cv[1] && (cd[1] == '0));
  assign pend_ext   = {8'd0, pend_id_r};
  assign head_ext   = {8'd0, cid[0]};

  assign wave_v[0]  = wave0_v_r;
  assign wave_m[0]  = WAVE_SEARCH;
  assign wave_id[0] = wave0_id_r;
  assign wave_d[0]  = wave0_d_r;

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_cell
      logic                 nb_valid;
      logic [ID_BITS-1:0]   nb_id;
      logic [TIME_BITS-1:0] nb_delta;

      if (k == DEPTH - 1) begin : g_tail
        assign nb_valid = 1'b0;
        assign nb_id    = '0;
        assign nb_delta = '0;
      end else begin : g_mid
        assign nb_valid = cv[k+1];
        assign nb_id    = cid[k+1];
        assign nb_delta = cd[k+1];
      end

      // head is decremented on an accepted tick beat
      assign ctl[k].shift = wake_go;
      assign ctl[k].dec   = (k == 0) && in_acc && (in_tuser == OP_TICK) && cv[0];

      dlsq_cell #(
        .ID_BITS  (ID_BITS),
        .TIME_BITS(TIME_BITS)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl[k]),
        .nb_valid(nb_valid),
        .nb_id   (nb_id),
        .nb_delta(nb_delta),
        .win_v   (wave_v[k]),
        .win_m   (wave_m[k]),
        .win_id  (wave_id[k]),
        .win_d   (wave_d[k]),
        .wout_v  (wave_v[k+1]),
        .wout_m  (wave_m[k+1]),
        .wout_id (wave_id[k+1]),
        .wout_d  (wave_d[k+1]),
        .valid   (cv[k]),
        .id      (cid[k]),
        .delta   (cd[k]),
        .absorb  (absorb[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wave0_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // launch the insert wave on an accepted insert into a queue with room
      wave0_v_r <= in_acc && (in_tuser == OP_INSERT) && !full;
      if (wake_go || ((state_r == S_RES) && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser == OP_INSERT) begin
              pend_id_r <= in_id;
              if (full) begin
                pend_kind_r <= KIND_FULL;
                state_r     <= S_RES;
              end else begin
                pend_kind_r <= KIND_ACCEPT;
                wave0_id_r  <= in_id;
                wave0_d_r   <= in_dur_eff;
                state_r     <= S_INS;
              end
            end else if (cv[0]) begin
              state_r <= S_WAKE;
            end
          end
        end
        S_INS: begin
          if (|absorb) begin
            state_r <= S_RES;
          end
        end
        S_RES: begin
          if (out_free) begin
            out_kind_r  <= pend_kind_r;
            out_id_r    <= pend_ext[7:0];
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_WAKE: begin
          if (!head_due) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_kind_r  <= KIND_WAKE;
            out_id_r    <= head_ext[7:0];
            out_last_r  <= wake_last;
            if (wake_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `DLSQ_ASSERT_IMP(a_wave_in_chain, wave_v[DEPTH], 1'b0, "insert wave ran off the chain")
  `DLSQ_ASSERT_IMP(a_idle_no_wave, in_tready, wave_v == '0, "insert wave active while idle")
  `DLSQ_ASSERT_IMP(a_head_nonzero, in_tready && cv[0], cd[0] != '0, "idle head delta is zero")
  `DLSQ_ASSERT_NXT(a_absorb_once, |absorb, absorb == '0, "insert wave absorbed twice")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the delta list sleep queue: directed and random stimulus.
module tb_top import dlsq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int IN_W        = 24;
  localparam int HOLD_CYCLES = 400;   // long output hold-off for the backpressure test
  localparam int STALL_LIMIT = 5000;  // cycles with no beat on either side before giving up
  localparam int SETTLE      = DEPTH + 16;

  // one result beat as the block should present it
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] id;
    logic       last;
  } sleep_beat_t;

  // receiver behavior, switched at random between these modes
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_CADENCE, RX_HEAVY} rx_mode_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;   // thread_id [7:0], duration [23:8]
  logic            in_tuser = OP_INSERT;  // op
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [7:0]      out_tdata;       // woken_id
  logic [1:0]      out_tuser;       // kind
  logic            out_tlast;

  delta_list_sleep_queue_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow sleep list: sorted delta list, same update rules as the block.
  // ---------------------------------------------------------------------------
  logic [7:0]  shadow_id [DEPTH];
  logic [15:0] shadow_dt [DEPTH];
  int          shadow_count = 0;
  sleep_beat_t awaited_beats[$];   // results owed by the block, oldest first

  // run statistics
  int err_count   = 0;
  int n_accepted  = 0;
  int n_full      = 0;
  int n_ticks     = 0;
  int n_silent    = 0;
  int n_woken     = 0;
  int most_woken  = 0;

  function automatic void sleep_list_insert(input logic [7:0] tid, input logic [15:0] dur);
    logic [15:0] rem;
    int pos;
    rem = (dur == 16'd0) ? 16'd1 : dur;  // zero sleep counts as one tick
    pos = 0;
    if (shadow_count >= DEPTH) begin
      awaited_beats.push_back('{KIND_FULL, tid, 1'b1});
      n_full++;
      return;
    end
    // walk past every entry that wakes no later than the new one (ties go behind)
    while (pos < shadow_count && rem >= shadow_dt[pos]) begin
      rem -= shadow_dt[pos];
      pos++;
    end
    for (int j = shadow_count; j > pos; j--) begin
      shadow_id[j] = shadow_id[j-1];
      shadow_dt[j] = shadow_dt[j-1];
    end
    shadow_id[pos] = tid;
    shadow_dt[pos] = rem;
    shadow_count++;
    if (pos + 1 < shadow_count) shadow_dt[pos+1] -= rem;
    awaited_beats.push_back('{KIND_ACCEPT, tid, 1'b1});
    n_accepted++;
  endfunction

  function automatic void sleep_list_tick();
    int woke;
    woke = 0;
    n_ticks++;
    if (shadow_count == 0) begin
      n_silent++;
      return;
    end
    shadow_dt[0] -= 16'd1;
    while (woke < shadow_count && shadow_dt[woke] == 16'd0) woke++;
    for (int k = 0; k < woke; k++)
      awaited_beats.push_back('{KIND_WAKE, shadow_id[k], logic'(k + 1 == woke)});
    for (int j = woke; j < shadow_count; j++) begin
      shadow_id[j-woke] = shadow_id[j];
      shadow_dt[j-woke] = shadow_dt[j];
    end
    shadow_count -= woke;
    if (woke == 0) n_silent++;
    n_woken += woke;
    if (woke > most_woken) most_woken = woke;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge. Input beats feed the
  // shadow list first, then any output beat is checked against the oldest
  // expectation. Also the watchdog: too long without any beat ends the run.
  // ---------------------------------------------------------------------------
  sleep_beat_t want;
  bit          moved;
  int          idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        if (in_tuser == OP_INSERT) sleep_list_insert(in_tdata[7:0], in_tdata[23:8]);
        else sleep_list_tick();
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (awaited_beats.size() == 0) begin
          report_mismatch($sformatf("beat with nothing pending: kind %0d id %0d last %0b",
                                    out_tuser, out_tdata, out_tlast));
        end else begin
          want = awaited_beats.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch($sformatf("kind: expected %0d, got %0d", want.kind, out_tuser));
          if (out_tdata !== want.id)
            report_mismatch($sformatf("woken_id: expected %0d, got %0d", want.id, out_tdata));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last: expected %0b, got %0b (id %0d)",
                                      want.last, out_tlast, want.id));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                 idle_cycles, awaited_beats.size());
        $display("delta_list_sleep_queue_unit regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_tready follows a randomly chosen mode, except during a
  // requested hold-off, which this process counts down itself.
  // ---------------------------------------------------------------------------
  int       hold_asked = 0;
  int       hold_seen  = 0;
  int       hold_left  = 0;
  int       rx_left    = 0;
  int       rx_phase   = 0;
  rx_mode_t rx_mode    = RX_OPEN;

  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(10, 60);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:    out_tready <= 1'b1;
        RX_LIGHT:   out_tready <= ($urandom_range(0, 3) != 0);
        RX_CADENCE: out_tready <= (rx_phase % 3 != 0);
        default:    out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one beat per call, in bursts of random length with idle gaps.
  // Inputs change on the falling edge; the call returns at the accepting edge.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_item(input logic op, input logic [7:0] tid, input logic [15:0] dur);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
      // now and then a long burst so there are stretches with no idling
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {dur, tid};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // tick with nothing asleep: no result at all
  task automatic test_tick_on_empty();
    send_tick();
  endtask

  // fill all 16 slots with threads that wake on the same tick (zero sleep among
  // them), bounce one more insert off the full queue, then wake all 16 at once
  task automatic test_fill_and_mass_wake();
    logic [7:0] tid;
    for (int i = 0; i < DEPTH; i++) begin
      tid = (i == 0) ? 8'h00 : (i == DEPTH - 1) ? 8'hFF : 8'(i * 16 + 3);
      send_item(OP_INSERT, tid, (i % 2 == 0) ? 16'd0 : 16'd1);
    end
    send_item(OP_INSERT, 8'hFF, 16'hFFFF);  // rejected: queue full
    send_tick();
  endtask

  // longest sleep, ordering in front of it, a tie that lands behind its twin
  // with delta zero, a tick that wakes nobody, then a tick that wakes the pair
  task automatic test_ordering_and_ties();
    send_item(OP_INSERT, 8'hA5, 16'hFFFF);
    send_item(OP_INSERT, 8'h5A, 16'd2);
    send_item(OP_INSERT, 8'h3C, 16'd2);
    send_tick();
    send_tick();
  endtask

  // hold the output off for a long time while inserts and ticks keep coming
  task automatic test_output_backpressure();
    @(negedge clk);
    in_tvalid <= 1'b0;
    hold_asked++;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) send_tick();
      else send_item(OP_INSERT, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 3)));
    end
  endtask

  // random schedule: phases that lean toward inserts (queue fills, rejections)
  // alternate with phases that lean toward ticks (queue drains)
  task automatic test_random_schedule(input int n_items);
    bit          insert_heavy;
    int          pick;
    logic [15:0] dur;
    insert_heavy = 1'b0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 30 == 0) insert_heavy = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (insert_heavy ? (pick < 3) : (pick < 6)) begin
        send_tick();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8)       dur = 16'd0;
        else if (pick < 75) dur = 16'($urandom_range(1, 12));
        else if (pick < 97) dur = 16'($urandom_range(13, 60));
        else                dur = 16'($urandom_range(0, 65535));
        send_item(OP_INSERT, 8'($urandom_range(0, 255)), dur);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_tick_on_empty();
    test_fill_and_mass_wake();
    test_ordering_and_ties();
    test_output_backpressure();
    test_random_schedule(362);

    @(negedge clk);
    in_tvalid <= 1'b0;
    // drain, then give a silent tick time to retire before the verdict
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d inserts accepted, %0d rejected as full, %0d ticks (%0d silent)",
             n_accepted, n_full, n_ticks, n_silent);
    $display("%0d threads woken, up to %0d by one tick; output held off %0d cycles once",
             n_woken, most_woken, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("delta_list_sleep_queue_unit regression: pass");
    end else begin
      $display("%0d mismatches", err_count);
      $display("delta_list_sleep_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
